@@ rtl/keyed_light_slot_table_unit_macros.svh @@
// Assertion macros used by the keyed light slot table engine.
`ifndef KEYED_LIGHT_SLOT_TABLE_UNIT_MACROS_SVH
`define KEYED_LIGHT_SLOT_TABLE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KLST_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KLST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/klst_pkg.sv @@
// Types, codes and helper functions of the keyed light slot table.
`default_nettype none

package klst_pkg;

	typedef struct packed {
		logic [15:0] key;
		logic [23:0] radius;
		logic [23:0] decay;
		logic [31:0] expiry;
	} entry_t;

	typedef struct packed {
		logic        mode;
		logic [15:0] light_key;
		logic [23:0] new_radius;
		logic [23:0] new_decay;
		logic [31:0] new_expiry;
		logic [31:0] now_time;
		logic [15:0] elapsed_time;
	} req_t;

	typedef struct packed {
		logic [4:0] slot_index;
		logic [1:0] pick_kind;
		logic [5:0] live_count;
	} rsp_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT,
		ST_FINISH
	} state_t;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_DECAY = 1'b1;

	localparam logic [1:0] KIND_KEY    = 2'd0;
	localparam logic [1:0] KIND_FREE   = 2'd1;
	localparam logic [1:0] KIND_FORCED = 2'd2;
	localparam logic [1:0] KIND_DECAY  = 2'd3;

	localparam int LIVE_MAX   = 63;
	localparam int LOSS_SHIFT = 10;

	// A slot is dead when its radius is zero or its nonzero expiry has passed.
	function automatic logic slot_dead(input entry_t e, input logic [31:0] now);
		return (e.radius == 24'd0) || ((e.expiry != 32'd0) && (e.expiry < now));
	endfunction

endpackage

`default_nettype wire

@@ rtl/klst_req_if.sv @@
// Request channel of the keyed light slot table.
`default_nettype none

interface klst_req_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [15:0] light_key;
	logic [23:0] new_radius;
	logic [23:0] new_decay;
	logic [31:0] new_expiry;
	logic [31:0] now_time;
	logic [15:0] elapsed_time;

	modport source (
		output valid, mode, light_key, new_radius, new_decay, new_expiry, now_time,
			elapsed_time,
		input ready
	);

	modport sink (
		input valid, mode, light_key, new_radius, new_decay, new_expiry, now_time,
			elapsed_time,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/klst_rsp_if.sv @@
// Result channel of the keyed light slot table.
`default_nettype none

interface klst_rsp_if;
	logic       valid;
	logic       ready;
	logic [4:0] slot_index;
	logic [1:0] pick_kind;
	logic [5:0] live_count;

	modport source (
		output valid, slot_index, pick_kind, live_count,
		input ready
	);

	modport sink (
		input valid, slot_index, pick_kind, live_count,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/keyed_light_slot_table_unit.sv @@
// Top level of the keyed light slot table unit.
`default_nettype none

// A table of SLOT_COUNT light slots held in one synchronous memory. Every request
// is handled alone: the unit reads all slots in order, one per cycle, through a
// two-stage read and update pipeline (decay requests write each live slot back as
// it passes), then commits the chosen slot for an allocation and forms the single
// result. A decay request takes longer than an allocation, as the drain waits for
// its last write-back to leave the second stage; the scan is paced by the one read
// port of the slot memory. The result waits in an output register, so a stalled
// result side costs nothing until the next result is due. The table is empty right
// after reset through per-slot valid bits, with no clearing pass.
module keyed_light_slot_table_unit #(
	parameter int SLOT_COUNT = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	klst_req_if.sink          req,
	klst_rsp_if.source        rsp
);

	localparam int IdxW = $clog2(SLOT_COUNT);

	klst_pkg::req_t     req_in;
	klst_pkg::rsp_t     res, out_q;
	klst_pkg::mem_ctl_t mem_ctl;
	klst_pkg::entry_t   wdata, rdata;
	logic [IdxW-1:0]    raddr, waddr;
	logic               req_ready, req_accept, res_ready, res_done, out_valid_q;

	assign req_in.mode         = req.mode;
	assign req_in.light_key    = req.light_key;
	assign req_in.new_radius   = req.new_radius;
	assign req_in.new_decay    = req.new_decay;
	assign req_in.new_expiry   = req.new_expiry;
	assign req_in.now_time     = req.now_time;
	assign req_in.elapsed_time = req.elapsed_time;

	assign req.ready  = req_ready;
	assign req_accept = req.valid && req_ready;
	assign res_ready  = !out_valid_q || rsp.ready;

	klst_engine #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_accept(req_accept),
		.req_in    (req_in),
		.req_ready (req_ready),
		.res_ready (res_ready),
		.res_done  (res_done),
		.res       (res),
		.mem_ctl   (mem_ctl),
		.raddr     (raddr),
		.waddr     (waddr),
		.wdata     (wdata),
		.rdata     (rdata)
	);

	klst_slot_mem #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_slot_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (mem_ctl),
		.raddr (raddr),
		.waddr (waddr),
		.wdata (wdata),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_done) begin
			out_q <= res;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.slot_index = out_q.slot_index;
	assign rsp.pick_kind  = out_q.pick_kind;
	assign rsp.live_count = out_q.live_count;

endmodule

`default_nettype wire

@@ rtl/klst_slot_mem.sv @@
// Slot memory with one read and one write port and per-slot valid bits.
`default_nettype none

module klst_slot_mem #(
	parameter int SLOT_COUNT = 32,
	localparam int IdxW = $clog2(SLOT_COUNT)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  klst_pkg::mem_ctl_t ctl,
	input  logic [IdxW-1:0]   raddr,
	input  logic [IdxW-1:0]   waddr,
	input  klst_pkg::entry_t  wdata,
	output klst_pkg::entry_t  rdata
);

	klst_pkg::entry_t        mem [SLOT_COUNT];
	klst_pkg::entry_t        rdata_q;
	logic [SLOT_COUNT-1:0]   valid_q;
	logic                    rvld_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[waddr] <= wdata;
		end
		if (ctl.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	// Slots never written since reset read as all zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvld_q  <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				valid_q[waddr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rvld_q <= valid_q[raddr];
			end
		end
	end

	assign rdata = rvld_q ? rdata_q : '0;

endmodule

`default_nettype wire

@@ rtl/klst_engine.sv @@
// Sequencer and datapath that scan, update and write back the slot table.
`default_nettype none
`include "keyed_light_slot_table_unit_macros.svh"

module klst_engine #(
	parameter int SLOT_COUNT = 32,
	localparam int IdxW = $clog2(SLOT_COUNT),
	localparam int CntW = $clog2(SLOT_COUNT + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_accept,
	input  klst_pkg::req_t     req_in,
	output logic               req_ready,
	input  logic               res_ready,
	output logic               res_done,
	output klst_pkg::rsp_t     res,
	output klst_pkg::mem_ctl_t mem_ctl,
	output logic [IdxW-1:0]    raddr,
	output logic [IdxW-1:0]    waddr,
	output klst_pkg::entry_t   wdata,
	input  klst_pkg::entry_t   rdata
);

	localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOT_COUNT - 1);

	klst_pkg::state_t state_q, state_d;
	klst_pkg::req_t   req_q;
	klst_pkg::rsp_t   res_q;

	logic [IdxW-1:0] idx_q;
	logic            vld_s1;
	logic [IdxW-1:0] idx_s1;
	logic            vld_s2;
	logic [IdxW-1:0] idx_s2;
	klst_pkg::entry_t ent_s2;
	logic            live_s2;
	logic [29:0]     loss_s2;

	logic            khit_q, klive_q, fhit_q;
	logic [IdxW-1:0] kidx_q, fidx_q;
	logic [CntW-1:0] cnt_q;

	logic            key_hit, dead_s1, inc_s1, inc_s2;
	logic [39:0]     prod;
	logic [23:0]     newrad;
	logic            commit_wr;

	logic [IdxW-1:0] pick_idx;
	logic [1:0]      pick_kind;
	logic            was_live, new_live;
	logic [CntW-1:0] cnt_after, cnt_res;
	logic [31:0]     cnt_ext;
	klst_pkg::entry_t new_ent;

	always_comb begin
		state_d = state_q;
		case (state_q)
			klst_pkg::ST_IDLE: begin
				if (req_accept) begin
					state_d = klst_pkg::ST_SCAN;
				end
			end
			klst_pkg::ST_SCAN: begin
				if (idx_q == LastIdx) begin
					state_d = klst_pkg::ST_DRAIN;
				end
			end
			klst_pkg::ST_DRAIN: begin
				if (!vld_s1 && !vld_s2) begin
					state_d = klst_pkg::ST_COMMIT;
				end
			end
			klst_pkg::ST_COMMIT: begin
				state_d = klst_pkg::ST_FINISH;
			end
			klst_pkg::ST_FINISH: begin
				if (res_ready) begin
					state_d = klst_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = klst_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready     = (state_q == klst_pkg::ST_IDLE);
		mem_ctl.rd_en = (state_q == klst_pkg::ST_SCAN);
		commit_wr     = (state_q == klst_pkg::ST_COMMIT) && (req_q.mode == klst_pkg::MODE_ALLOC);
		mem_ctl.wr_en = commit_wr || (vld_s2 && live_s2);
		res_done      = (state_q == klst_pkg::ST_FINISH) && res_ready;
	end

	// First stage: classify the slot just read.
	assign key_hit = (req_q.light_key != 16'd0) && (rdata.key == req_q.light_key);
	assign dead_s1 = klst_pkg::slot_dead(rdata, req_q.now_time);
	assign inc_s1  = vld_s1 && (req_q.mode == klst_pkg::MODE_ALLOC) && !dead_s1;
	assign prod    = 40'(req_q.elapsed_time) * 40'(rdata.decay);

	// Second stage: saturating radius update of a live slot.
	assign newrad = (loss_s2 >= {6'd0, ent_s2.radius}) ? 24'd0 :
		ent_s2.radius - loss_s2[23:0];
	assign inc_s2 = vld_s2 && live_s2 && (newrad != 24'd0);

	always_comb begin
		if (khit_q) begin
			pick_idx  = kidx_q;
			pick_kind = klst_pkg::KIND_KEY;
			was_live  = klive_q;
		end else if (fhit_q) begin
			pick_idx  = fidx_q;
			pick_kind = klst_pkg::KIND_FREE;
			was_live  = 1'b0;
		end else begin
			pick_idx  = '0;
			pick_kind = klst_pkg::KIND_FORCED;
			was_live  = 1'b1;
		end
		new_ent.key    = req_q.light_key;
		new_ent.radius = req_q.new_radius;
		new_ent.decay  = req_q.new_decay;
		new_ent.expiry = req_q.new_expiry;
		new_live  = !klst_pkg::slot_dead(new_ent, req_q.now_time);
		cnt_after = cnt_q - CntW'(was_live) + CntW'(new_live);
		cnt_res   = (req_q.mode == klst_pkg::MODE_ALLOC) ? cnt_after : cnt_q;
		cnt_ext   = 32'(cnt_res);
	end

	always_comb begin
		raddr = idx_q;
		if (commit_wr) begin
			waddr = pick_idx;
			wdata = new_ent;
		end else begin
			waddr        = idx_s2;
			wdata        = ent_s2;
			wdata.radius = newrad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= klst_pkg::ST_IDLE;
			idx_q   <= '0;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			khit_q  <= 1'b0;
			klive_q <= 1'b0;
			fhit_q  <= 1'b0;
			kidx_q  <= '0;
			fidx_q  <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			vld_s1  <= mem_ctl.rd_en;
			vld_s2  <= vld_s1 && (req_q.mode == klst_pkg::MODE_DECAY);
			if (req_accept) begin
				idx_q  <= '0;
				khit_q <= 1'b0;
				fhit_q <= 1'b0;
				cnt_q  <= '0;
			end else begin
				if (mem_ctl.rd_en) begin
					idx_q <= idx_q + IdxW'(1);
				end
				if (vld_s1 && (req_q.mode == klst_pkg::MODE_ALLOC)) begin
					if (key_hit && !khit_q) begin
						khit_q  <= 1'b1;
						kidx_q  <= idx_s1;
						klive_q <= !dead_s1;
					end
					if (dead_s1 && !fhit_q) begin
						fhit_q <= 1'b1;
						fidx_q <= idx_s1;
					end
				end
				cnt_q <= cnt_q + CntW'(inc_s1) + CntW'(inc_s2);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			req_q <= req_in;
		end
		idx_s1  <= idx_q;
		idx_s2  <= idx_s1;
		ent_s2  <= rdata;
		live_s2 <= !dead_s1;
		loss_s2 <= prod[39:klst_pkg::LOSS_SHIFT];
		if (state_q == klst_pkg::ST_COMMIT) begin
			res_q.slot_index <= (req_q.mode == klst_pkg::MODE_ALLOC) ? 5'(pick_idx) : 5'd0;
			res_q.pick_kind  <= (req_q.mode == klst_pkg::MODE_ALLOC) ? pick_kind :
				klst_pkg::KIND_DECAY;
			res_q.live_count <= (cnt_ext > 32'(klst_pkg::LIVE_MAX)) ?
				6'(klst_pkg::LIVE_MAX) : cnt_ext[5:0];
		end
	end

	assign res = res_q;

	`KLST_ASSERT_NOW(a_no_port_clash, mem_ctl.rd_en && mem_ctl.wr_en, raddr != waddr, "read and write hit the same slot")
	`KLST_ASSERT_NOW(a_drained, state_q == klst_pkg::ST_COMMIT, !vld_s1 && !vld_s2, "commit before the scan pipeline drained")
	`KLST_ASSERT_NOW(a_write_source, mem_ctl.wr_en && !commit_wr, vld_s2 && (req_q.mode == klst_pkg::MODE_DECAY), "slot written outside a decay update or commit")
	`KLST_ASSERT_NOW(a_kind_mode, state_q == klst_pkg::ST_FINISH, (res_q.pick_kind == klst_pkg::KIND_DECAY) == (req_q.mode == klst_pkg::MODE_DECAY), "result kind does not match the request mode")
	`KLST_ASSERT_NEXT(a_count_bound, state_q == klst_pkg::ST_COMMIT, 32'(cnt_q) <= 32'(SLOT_COUNT), "live count exceeds the table size")

endmodule

`default_nettype wire

@@ dv/tb_keyed_light_slot_table_unit.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the keyed light slot table unit with its own table predictor.
module tb_keyed_light_slot_table_unit;

	localparam int SLOTS = 32;
	localparam int TARGET_REQUESTS = 850;
	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_AT = 300;
	localparam int HOLD_CYCLES = 600;
	localparam int DRAIN_CYCLES = 2 * (SLOTS + 5);

	typedef enum int {SEQ_FILL, SEQ_MIXED, SEQ_NOISE} seq_kind_t;

	class light_table_scoreboard;
		logic [15:0] owner[SLOTS];
		logic [23:0] radius[SLOTS];
		logic [23:0] rate[SLOTS];
		logic [31:0] expiry[SLOTS];
		klst_pkg::rsp_t expected_results[$];
		int errors;
		int checked;
		int kind_seen[4];

		function new();
			foreach (owner[i]) begin
				owner[i] = '0;
				radius[i] = '0;
				rate[i] = '0;
				expiry[i] = '0;
			end
			foreach (kind_seen[k])
				kind_seen[k] = 0;
			errors = 0;
			checked = 0;
		endfunction

		function bit dead_at(int i, logic [31:0] now);
			return (radius[i] == 24'd0) || ((expiry[i] != 32'd0) && (expiry[i] < now));
		endfunction

		function klst_pkg::rsp_t apply_request(klst_pkg::req_t r);
			klst_pkg::rsp_t res;
			int pick;
			logic [1:0] kind;
			logic [39:0] loss;
			int live;
			pick = 0;
			kind = klst_pkg::KIND_DECAY;
			if (r.mode == klst_pkg::MODE_ALLOC) begin
				kind = klst_pkg::KIND_FORCED;
				if (r.light_key != 16'd0) begin
					for (int i = 0; i < SLOTS; i++) begin
						if (kind == klst_pkg::KIND_FORCED && owner[i] == r.light_key) begin
							pick = i;
							kind = klst_pkg::KIND_KEY;
						end
					end
				end
				for (int i = 0; i < SLOTS; i++) begin
					if (kind == klst_pkg::KIND_FORCED && dead_at(i, r.now_time)) begin
						pick = i;
						kind = klst_pkg::KIND_FREE;
					end
				end
				owner[pick] = r.light_key;
				radius[pick] = r.new_radius;
				rate[pick] = r.new_decay;
				expiry[pick] = r.new_expiry;
			end else begin
				for (int i = 0; i < SLOTS; i++) begin
					if (!dead_at(i, r.now_time)) begin
						loss = (40'(r.elapsed_time) * 40'(rate[i])) >> klst_pkg::LOSS_SHIFT;
						if (loss >= 40'(radius[i]))
							radius[i] = 24'd0;
						else
							radius[i] = radius[i] - loss[23:0];
					end
				end
			end
			live = 0;
			for (int i = 0; i < SLOTS; i++)
				if (!dead_at(i, r.now_time))
					live++;
			if (live > klst_pkg::LIVE_MAX)
				live = klst_pkg::LIVE_MAX;
			res.slot_index = 5'(pick);
			res.pick_kind = kind;
			res.live_count = 6'(live);
			return res;
		endfunction

		function void note_request(klst_pkg::req_t r);
			klst_pkg::rsp_t res;
			res = apply_request(r);
			kind_seen[res.pick_kind]++;
			expected_results.push_back(res);
		endfunction

		task report(string what);
			errors++;
			$display("MISMATCH at %0t: %s", $time, what);
		endtask

		task check_result(klst_pkg::rsp_t got);
			klst_pkg::rsp_t want;
			if (expected_results.size() == 0) begin
				report("result arrived with no request pending");
				return;
			end
			want = expected_results.pop_front();
			checked++;
			if (got.slot_index !== want.slot_index)
				report($sformatf("result %0d slot_index %0d, expected %0d",
					checked, got.slot_index, want.slot_index));
			if (got.pick_kind !== want.pick_kind)
				report($sformatf("result %0d pick_kind %0d, expected %0d",
					checked, got.pick_kind, want.pick_kind));
			if (got.live_count !== want.live_count)
				report($sformatf("result %0d live_count %0d, expected %0d",
					checked, got.live_count, want.live_count));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	klst_req_if req_ch ();
	klst_rsp_if rsp_ch ();
	light_table_scoreboard table_sb = new();
	int sent = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	logic [31:0] clock_now = '0;

	keyed_light_slot_table_unit #(.SLOT_COUNT(SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic klst_pkg::req_t alloc_req(logic [15:0] key, logic [23:0] rad,
			logic [23:0] dec, logic [31:0] expire_at, logic [31:0] now);
		klst_pkg::req_t r;
		r.mode = klst_pkg::MODE_ALLOC;
		r.light_key = key;
		r.new_radius = rad;
		r.new_decay = dec;
		r.new_expiry = expire_at;
		r.now_time = now;
		r.elapsed_time = 16'($urandom);
		return r;
	endfunction

	function automatic klst_pkg::req_t decay_req(logic [31:0] now, logic [15:0] elapsed);
		klst_pkg::req_t r;
		r.mode = klst_pkg::MODE_DECAY;
		r.light_key = 16'($urandom);
		r.new_radius = 24'($urandom);
		r.new_decay = 24'($urandom);
		r.new_expiry = $urandom;
		r.now_time = now;
		r.elapsed_time = elapsed;
		return r;
	endfunction

	function automatic klst_pkg::req_t next_request(seq_kind_t flavor);
		klst_pkg::req_t r;
		int c;
		if (flavor == SEQ_NOISE) begin
			r = decay_req($urandom, 16'($urandom));
			r.mode = 1'($urandom);
			return r;
		end
		if (flavor == SEQ_FILL) begin
			r = alloc_req(($urandom_range(0, 4) < 3) ? 16'd0 : 16'($urandom),
				24'($urandom_range(1, 24'hFFFFFF)), 24'($urandom_range(0, 255)),
				($urandom_range(0, 1) == 0) ? 32'd0 : clock_now + $urandom_range(5000, 100000),
				clock_now);
			clock_now = clock_now + $urandom_range(0, 4);
			return r;
		end
		c = $urandom_range(0, 19);
		if (c < 5)
			r.light_key = 16'd0;
		else if (c < 15)
			r.light_key = 16'($urandom_range(1, 6));
		else if (c < 19)
			r.light_key = 16'($urandom);
		else
			r.light_key = 16'hFFFF;
		c = $urandom_range(0, 9);
		if (c == 0)
			r.new_radius = 24'd0;
		else if (c < 3)
			r.new_radius = 24'($urandom_range(1, 255));
		else if (c == 3)
			r.new_radius = 24'hFFFFFF;
		else
			r.new_radius = 24'($urandom);
		c = $urandom_range(0, 9);
		if (c == 0)
			r.new_decay = 24'd0;
		else if (c < 6)
			r.new_decay = 24'($urandom_range(1, 4096));
		else
			r.new_decay = 24'($urandom);
		c = $urandom_range(0, 19);
		if (c == 19)
			clock_now = $urandom;
		else
			clock_now = clock_now + $urandom_range(0, 300);
		r.now_time = clock_now;
		c = $urandom_range(0, 9);
		if (c < 3)
			r.new_expiry = 32'd0;
		else if (c < 7)
			r.new_expiry = clock_now + $urandom_range(0, 2000);
		else if (c == 7)
			r.new_expiry = clock_now - $urandom_range(1, 100);
		else if (c == 8)
			r.new_expiry = clock_now;
		else
			r.new_expiry = $urandom;
		c = $urandom_range(0, 9);
		if (c == 0)
			r.elapsed_time = 16'd0;
		else if (c < 6)
			r.elapsed_time = 16'($urandom_range(1, 64));
		else if (c < 9)
			r.elapsed_time = 16'($urandom);
		else
			r.elapsed_time = 16'hFFFF;
		r.mode = ($urandom_range(0, 3) == 0) ? klst_pkg::MODE_DECAY : klst_pkg::MODE_ALLOC;
		return r;
	endfunction

	task send_request(klst_pkg::req_t r);
		req_ch.valid <= 1'b1;
		req_ch.mode <= r.mode;
		req_ch.light_key <= r.light_key;
		req_ch.new_radius <= r.new_radius;
		req_ch.new_decay <= r.new_decay;
		req_ch.new_expiry <= r.new_expiry;
		req_ch.now_time <= r.now_time;
		req_ch.elapsed_time <= r.elapsed_time;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		table_sb.note_request(r);
		sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
				: $urandom_range(0, 20);
		end
	endtask

	initial begin
		seq_kind_t flavor;
		int run_len;
		int p;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.mode <= klst_pkg::MODE_ALLOC;
		req_ch.light_key <= '0;
		req_ch.new_radius <= '0;
		req_ch.new_decay <= '0;
		req_ch.new_expiry <= '0;
		req_ch.now_time <= '0;
		req_ch.elapsed_time <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(decay_req(32'd0, 16'hFFFF));
		send_request(alloc_req(16'd0, 24'hFFFFFF, 24'd0, 32'd0, 32'd0));
		send_request(alloc_req(16'hFFFF, 24'd1, 24'hFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
		send_request(alloc_req(16'hFFFF, 24'd0, 24'd0, 32'd0, 32'hFFFFFFFF));
		// The same key comes back while its slot is dead and must still be reused.
		send_request(alloc_req(16'hFFFF, 24'd100, 24'hFFFFFF, 32'd0, 32'd10));
		send_request(alloc_req(16'd5, 24'd1000, 24'd1024, 32'd50, 32'd10));
		send_request(alloc_req(16'd6, 24'd500, 24'd341, 32'd0, 32'd10));
		send_request(decay_req(32'd10, 16'd1));
		send_request(decay_req(32'd10, 16'd3));
		send_request(decay_req(32'd51, 16'd100));
		send_request(alloc_req(16'd0, 24'd7, 24'd2, 32'd100, 32'd51));
		send_request(alloc_req(16'd0, 24'd8, 24'd0, 32'd0, 32'd51));
		send_request(alloc_req(16'd9, 24'd9, 24'd0, 32'd100, 32'd100));
		send_request(decay_req(32'd0, 16'd0));
		send_request(alloc_req(16'd5, 24'd3, 24'd0, 32'd0, 32'd0));
		send_request(alloc_req(16'd0, 24'hFFFFFF, 24'hFFFFFF, 32'd0, 32'd0));
		send_request(decay_req(32'd0, 16'hFFFF));
		send_request(decay_req(32'hFFFFFFFF, 16'd1));

		clock_now = 32'd1000;
		while (sent < TARGET_REQUESTS) begin
			p = $urandom_range(0, 99);
			if (p < 15) begin
				flavor = SEQ_FILL;
				run_len = $urandom_range(33, 40);
			end else if (p < 85) begin
				flavor = SEQ_MIXED;
				run_len = $urandom_range(10, 30);
			end else begin
				flavor = SEQ_NOISE;
				run_len = $urandom_range(1, 4);
			end
			repeat (run_len) send_request(next_request(flavor));
		end
		req_ch.valid <= 1'b0;

		while (table_sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d results of %0d requests: %0d key reuses, %0d free slots,",
			table_sb.checked, sent, table_sb.kind_seen[klst_pkg::KIND_KEY],
			table_sb.kind_seen[klst_pkg::KIND_FREE]);
		$display("%0d forced to slot 0, %0d decay ticks; fills, keyed churn, noise, one long stall.",
			table_sb.kind_seen[klst_pkg::KIND_FORCED], table_sb.kind_seen[klst_pkg::KIND_DECAY]);
		if (table_sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		klst_pkg::rsp_t got;
		int hold_left;
		int segment_left;
		int stall_pct;
		bit held;
		hold_left = 0;
		segment_left = 0;
		stall_pct = 0;
		held = 1'b0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				got.slot_index = rsp_ch.slot_index;
				got.pick_kind = rsp_ch.pick_kind;
				got.live_count = rsp_ch.live_count;
				table_sb.check_result(got);
			end
			if (!held && table_sb.checked == HOLD_AT) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
				rsp_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
			end else begin
				if (segment_left == 0) begin
					p_pick: case ($urandom_range(0, 4))
						0, 1: stall_pct = 0;
						2: stall_pct = 25;
						3: stall_pct = 50;
						default: stall_pct = 90;
					endcase
					segment_left = $urandom_range(20, 200);
				end
				segment_left--;
				rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
				|| (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("No request moved for %0d cycles.", IDLE_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

endmodule
